FILE: rtl/le_pkg.sv
`default_nettype none
package le_pkg;

	// Line store geometry
	localparam int LINE_BUFFER_DEPTH = 512;
	localparam int ADDR_W            = 9;
	localparam logic [9:0] LIMIT_MIN = 10'd2;
	localparam logic [9:0] LIMIT_MAX = 10'(LINE_BUFFER_DEPTH);
	localparam logic [9:0] LIMIT_RESET = 10'd512;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Character codes
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_UC_C  = 8'h43;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_EOF  = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_LINE = 2'd1,
		KIND_EOS  = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	// Result sequences the back end plays out
	typedef enum logic [2:0] {
		SEQ_ECHO      = 3'd0,
		SEQ_ECHO_DONE = 3'd1,
		SEQ_ERASE     = 3'd2,
		SEQ_INTR      = 3'd3,
		SEQ_DONE      = 3'd4,
		SEQ_EOS       = 3'd5,
		SEQ_READ      = 3'd6
	} seq_t;

	typedef struct packed {
		seq_t        seq;
		logic [7:0]  data;
		logic [8:0]  len;
	} op_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [8:0]  len;
		logic        last;
	} res_t;

	// Result for one step of a sequence
	function automatic res_t expand(op_t op, logic [1:0] step);
		res_t r;
		r.kind = KIND_ECHO;
		r.data = 8'd0;
		r.len  = 9'd0;
		r.last = 1'b1;
		unique case (op.seq)
			SEQ_ECHO: begin
				r.data = op.data;
			end
			SEQ_ECHO_DONE: begin
				if (step == 2'd0) begin
					r.data = op.data;
					r.last = 1'b0;
				end else begin
					r.kind = KIND_LINE;
					r.len  = op.len;
				end
			end
			SEQ_ERASE: begin
				r.data = (step == 2'd1) ? CH_SPACE : CH_BS;
				r.last = (step == 2'd2);
			end
			SEQ_INTR: begin
				unique case (step)
					2'd0: begin
						r.data = CH_CARET;
						r.last = 1'b0;
					end
					2'd1: begin
						r.data = CH_UC_C;
						r.last = 1'b0;
					end
					2'd2: begin
						r.data = CH_LF;
						r.last = 1'b0;
					end
					default: begin
						r.kind = KIND_LINE;
					end
				endcase
			end
			SEQ_DONE: begin
				r.kind = KIND_LINE;
				r.len  = op.len;
			end
			SEQ_EOS: begin
				r.kind = KIND_EOS;
			end
			SEQ_READ: begin
				r.kind = KIND_READ;
				r.data = op.data;
			end
			default: begin
				r.last = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/le_if.sv
`default_nettype none
interface le_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  in_byte;
	logic [8:0]  read_index;
	modport source (output valid, cmd, in_byte, read_index, input ready);
	modport sink (input valid, cmd, in_byte, read_index, output ready);
endinterface

interface le_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [8:0]  line_length;
	logic        last;
	modport source (output valid, kind, data_byte, line_length, last, input ready);
	modport sink (input valid, kind, data_byte, line_length, last, output ready);
endinterface

interface le_cfg_if;
	logic        valid;
	logic        ready;
	logic [9:0]  data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/le_ram.sv
`default_nettype none
module le_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or registered read, one address per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/le_front.sv
`default_nettype none
module le_front (
	input  logic          clk,
	input  logic          arst_n,
	le_item_if.sink       item,
	le_cfg_if.sink        cfg,
	output logic          push,
	output le_pkg::op_t   push_op,
	input  logic          q_full
);
	import le_pkg::*;

	logic [9:0]  line_limit_q;
	logic [8:0]  edit_pos_q;
	logic [8:0]  done_len_q;
	logic        vld_s1;
	op_t         op_s1;
	logic        zero_s1;

	logic [9:0]  lim_c;
	logic [9:0]  cap_w;
	logic [8:0]  cap_c;
	logic        accept;
	logic        emit_c;
	op_t         op_c;
	logic        zero_c;
	logic [8:0]  edit_pos_nxt;
	logic [8:0]  done_len_nxt;
	logic        ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]  ram_rdata;
	logic        printable;

	assign cfg.ready  = 1'b1;
	assign item.ready = !vld_s1 || !q_full;
	assign accept     = item.valid && item.ready;
	assign push       = vld_s1 && !q_full;

	// Clamp the limit and derive the line capacity
	always_comb begin
		if (line_limit_q < LIMIT_MIN) begin
			lim_c = LIMIT_MIN;
		end else if (line_limit_q > LIMIT_MAX) begin
			lim_c = LIMIT_MAX;
		end else begin
			lim_c = line_limit_q;
		end
	end
	assign cap_w = lim_c - 10'd1;
	assign cap_c = cap_w[8:0];

	assign printable = (item.in_byte >= CH_SPACE) && (item.in_byte < CH_DEL);

	// Classify the item and work out the edit state it leaves
	always_comb begin
		emit_c       = 1'b0;
		op_c.seq     = SEQ_ECHO;
		op_c.data    = item.in_byte;
		op_c.len     = 9'd0;
		zero_c       = 1'b0;
		edit_pos_nxt = edit_pos_q;
		done_len_nxt = done_len_q;
		ram_we       = 1'b0;
		ram_addr     = edit_pos_q;
		unique case (cmd_t'(item.cmd))
			CMD_BYTE: begin
				if ({1'b0, edit_pos_q} >= cap_w) begin
					emit_c       = 1'b1;
					op_c.seq     = SEQ_DONE;
					op_c.len     = cap_c;
					done_len_nxt = cap_c;
					edit_pos_nxt = 9'd0;
				end else if (item.in_byte == CH_LF || item.in_byte == CH_CR) begin
					emit_c       = 1'b1;
					op_c.seq     = SEQ_ECHO_DONE;
					op_c.data    = CH_LF;
					op_c.len     = edit_pos_q;
					done_len_nxt = edit_pos_q;
					edit_pos_nxt = 9'd0;
				end else if (item.in_byte == CH_DEL || item.in_byte == CH_BS) begin
					if (edit_pos_q != 9'd0) begin
						emit_c       = 1'b1;
						op_c.seq     = SEQ_ERASE;
						edit_pos_nxt = edit_pos_q - 9'd1;
					end
				end else if (item.in_byte == CH_ETX) begin
					emit_c       = 1'b1;
					op_c.seq     = SEQ_INTR;
					done_len_nxt = 9'd0;
					edit_pos_nxt = 9'd0;
				end else if (printable) begin
					emit_c = 1'b1;
					ram_we = 1'b1;
					if ({1'b0, edit_pos_q + 9'd1} >= cap_w) begin
						op_c.seq     = SEQ_ECHO_DONE;
						op_c.len     = cap_c;
						done_len_nxt = cap_c;
						edit_pos_nxt = 9'd0;
					end else begin
						edit_pos_nxt = edit_pos_q + 9'd1;
					end
				end
			end
			CMD_EOF: begin
				emit_c = 1'b1;
				if (edit_pos_q != 9'd0) begin
					op_c.seq     = SEQ_DONE;
					op_c.len     = edit_pos_q;
					done_len_nxt = edit_pos_q;
					edit_pos_nxt = 9'd0;
				end else begin
					op_c.seq     = SEQ_EOS;
					done_len_nxt = 9'd0;
				end
			end
			CMD_READ: begin
				emit_c   = 1'b1;
				op_c.seq = SEQ_READ;
				zero_c   = !(item.read_index < done_len_q);
				ram_addr = item.read_index;
			end
			CMD_NONE: begin
				emit_c = 1'b0;
			end
		endcase
	end

	le_ram #(
		.WIDTH (8),
		.DEPTH (LINE_BUFFER_DEPTH)
	) u_line_store (
		.clk   (clk),
		.en    (accept),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (item.in_byte),
		.rdata (ram_rdata)
	);

	// Hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			line_limit_q <= cfg.data;
		end
	end

	// Advance edit state on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edit_pos_q <= 9'd0;
			done_len_q <= 9'd0;
		end else if (accept) begin
			edit_pos_q <= edit_pos_nxt;
			done_len_q <= done_len_nxt;
		end
	end

	// Stage 1: wait for read data, then push to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= emit_c;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_c;
			zero_s1 <= zero_c;
		end
	end

	// Merge the store read into a read op
	always_comb begin
		push_op = op_s1;
		if (op_s1.seq == SEQ_READ) begin
			push_op.data = zero_s1 ? 8'd0 : ram_rdata;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/le_queue.sv
`default_nettype none
module le_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  le_pkg::op_t   push_op,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output le_pkg::op_t   head
);
	import le_pkg::*;

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/le_back.sv
`default_nettype none
module le_back (
	input  logic          clk,
	input  logic          arst_n,
	input  le_pkg::op_t   head,
	input  logic          empty,
	output logic          pop,
	le_result_if.source   result
);
	import le_pkg::*;

	logic        out_vld_q;
	res_t        res_q;
	logic [1:0]  step_q;
	res_t        res_c;
	logic        load;
	logic        take;

	assign res_c = expand(head, step_q);
	assign load  = !out_vld_q || result.ready;
	assign take  = load && !empty;
	assign pop   = take && res_c.last;

	assign result.valid       = out_vld_q;
	assign result.kind        = res_q.kind;
	assign result.data_byte   = res_q.data;
	assign result.line_length = res_q.len;
	assign result.last        = res_q.last;

	// Output register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			step_q    <= 2'd0;
		end else begin
			if (load) begin
				out_vld_q <= !empty;
			end
			if (take) begin
				step_q <= pop ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_c;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/line_editor_with_echo.sv
// Canonical terminal line editor with echo.
// Channels: item takes a command (byte received, end of input, read of the
// completed line); result returns echo bytes, line-complete and end-of-stream
// status, and read data, with last set on the final result of each item;
// cfg writes the line limit register (a line completes at limit - 1 bytes).
// The first result of an item passes the front-end stage register, the
// queue and the output register. Throughput: one result per cycle while
// the receiver is ready; an item gives one to four results by its kind,
// and items with no result skip the queue. The front end accepts an item
// per cycle while the four-entry queue has room, and the line store is a
// single-port RAM used once per item.
// Reset: line limit 512, empty edit line, completed length 0; store contents
// are undefined until typed. When the receiver stalls, the result is held in
// the output register, the queue fills, and then item.ready drops.
`default_nettype none
module line_editor_with_echo (
	input  logic         clk,
	input  logic         arst_n,
	le_item_if.sink      item,
	le_cfg_if.sink       cfg,
	le_result_if.source  result
);
	import le_pkg::*;

	logic  push;
	op_t   push_op;
	logic  q_full;
	logic  pop;
	logic  q_empty;
	op_t   head;

	le_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.push    (push),
		.push_op (push_op),
		.q_full  (q_full)
	);

	le_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.head    (head)
	);

	le_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

FILE: rtl/le_checker.sv
`default_nettype none
module le_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [1:0]  res_kind,
	input  logic [7:0]  res_data,
	input  logic [8:0]  res_len,
	input  logic        res_last
);
	import le_pkg::*;

	// Stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// Stalled result payload holds
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_kind) && $stable(res_data)
			&& $stable(res_len) && $stable(res_last))
		else $error("result payload changed while stalled");

	// Results of one item come without gaps
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> res_valid)
		else $error("gap inside the results of one item");

	// Only echo bytes are followed by more results of the same item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_ECHO |-> res_last)
		else $error("status or read result without last");

endmodule

bind line_editor_with_echo le_checker u_le_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_kind  (result.kind),
	.res_data  (result.data_byte),
	.res_len   (result.line_length),
	.res_last  (result.last)
);
`default_nettype wire
